// File: hw/rtl/atx_pkg.sv
// Shared types, constants and helpers for the affine point transform core.
package atx_pkg;

  localparam int COEF_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PT_WIDTH   = 32;
  localparam int PROD_W     = COEF_WIDTH + PT_WIDTH;
  localparam int ACC_W      = PROD_W + 3;
  localparam int NROWS      = 3;
  localparam int NCOLS      = 4;
  localparam int NCOEF      = NROWS * NCOLS;
  localparam int IDX_W      = $clog2(NCOEF);
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);
  localparam int QCW        = $clog2(QDEPTH + 1);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } opcode_t;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic signed [PT_WIDTH-1:0]   pt_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [1:0]         row_sel;
    logic [1:0]         col_sel;
    logic signed [31:0] coef_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] point_w;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               sat_flag;
  } out_item_t;

  typedef struct packed {
    logic                    is_load;
    logic [IDX_W-1:0]        idx;
    coef_t                   coef;
    logic [NCOLS-1:0][PT_WIDTH-1:0] pt;
  } q_item_t;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QCW-1:0] count;
  } q_stat_t;

  localparam logic [1:0] ROW_LAST = 2'(NROWS - 1);

  localparam logic [63:0] ONE64    = 64'(1) << FRAC_BITS;
  localparam coef_t       COEF_ONE = ONE64[COEF_WIDTH-1:0];
  localparam coef_t       COEF_ZERO = '0;

  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_BITS - 1);

  localparam logic signed [PT_WIDTH-1:0] OUT_MAX = {1'b0, {(PT_WIDTH-1){1'b1}}};
  localparam logic signed [PT_WIDTH-1:0] OUT_MIN = {1'b1, {(PT_WIDTH-1){1'b0}}};

  function automatic coef_t wrap_coef(input logic signed [31:0] v);
    logic signed [63:0] ext;
    ext = 64'(v);
    return ext[COEF_WIDTH-1:0];
  endfunction

endpackage

// File: hw/rtl/atx_front.sv
// Front end: classifies incoming items and turns them into queue entries.
module atx_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  atx_pkg::in_item_t in_data,
  input  atx_pkg::q_stat_t  q_stat,
  output logic              push,
  output atx_pkg::q_item_t  push_item
);

  logic is_load;
  logic drop;

  assign is_load  = (in_data.opcode == atx_pkg::OP_LOAD);
  assign drop     = is_load && (in_data.row_sel > atx_pkg::ROW_LAST);
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full && !drop;

  always_comb begin
    push_item.is_load = is_load;
    push_item.idx     = atx_pkg::IDX_W'(in_data.row_sel) * atx_pkg::IDX_W'(atx_pkg::NCOLS)
                        + atx_pkg::IDX_W'(in_data.col_sel);
    push_item.coef    = atx_pkg::wrap_coef(in_data.coef_value);
    push_item.pt[0]   = in_data.point_x;
    push_item.pt[1]   = in_data.point_y;
    push_item.pt[2]   = in_data.point_z;
    push_item.pt[3]   = in_data.point_w;
  end

endmodule

// File: hw/rtl/atx_queue.sv
// Short FIFO between the front end and the arithmetic back end.
module atx_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  atx_pkg::q_item_t push_item,
  input  logic             pop,
  output atx_pkg::q_item_t head_item,
  output atx_pkg::q_stat_t q_stat
);

  atx_pkg::q_item_t               mem_r [atx_pkg::QDEPTH];
  logic [atx_pkg::QAW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [atx_pkg::QAW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [atx_pkg::QCW-1:0]        count_r, count_nxt;

  assign head_item    = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == atx_pkg::QCW'(atx_pkg::QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign q_stat.count = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == atx_pkg::QAW'(atx_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == atx_pkg::QAW'(atx_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: hw/rtl/atx_back.sv
// Back end: coefficient matrix, multiply/add tree, rounding and saturation.
module atx_back (
  input  logic               clk,
  input  logic               rst_n,
  input  atx_pkg::q_item_t   head_item,
  input  atx_pkg::q_stat_t   q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output atx_pkg::out_item_t out_data
);

  localparam int NR = atx_pkg::NROWS;
  localparam int NC = atx_pkg::NCOLS;
  localparam int AW = atx_pkg::ACC_W;
  localparam int PW = atx_pkg::PROD_W;
  localparam int TW = atx_pkg::PT_WIDTH;

  atx_pkg::coef_t           coef_r [atx_pkg::NCOEF];
  logic signed [PW-1:0]     prod_r [NR][NC];
  logic signed [PW-1:0]     prod_nxt [NR][NC];
  logic signed [AW-1:0]     sum_r [NR][2];
  logic signed [AW-1:0]     sum_nxt [NR][2];
  logic signed [AW-1:0]     rnd_r [NR];
  logic signed [AW-1:0]     rnd_nxt [NR];
  logic signed [AW-1:0]     shf [NR];
  logic signed [TW-1:0]     res [NR];
  logic [NR-1:0]            sat;
  logic                     v1_r, v2_r, v3_r;
  logic                     out_valid_r;
  atx_pkg::out_item_t       out_data_r, out_data_nxt;
  logic                     adv;

  assign adv       = !out_valid_r || !out_stall;
  assign pop       = !q_stat.empty && adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    for (int r = 0; r < NR; r++) begin
      for (int c = 0; c < NC; c++) begin
        prod_nxt[r][c] = PW'(coef_r[r*NC + c]) * PW'($signed(head_item.pt[c]));
      end
      sum_nxt[r][0] = AW'(prod_r[r][0]) + AW'(prod_r[r][1]);
      sum_nxt[r][1] = AW'(prod_r[r][2]) + AW'(prod_r[r][3]);
      rnd_nxt[r]    = sum_r[r][0] + sum_r[r][1] + atx_pkg::HALF_LSB;
      shf[r]        = rnd_r[r] >>> atx_pkg::FRAC_BITS;
      if ((&shf[r][AW-1:TW-1]) || !(|shf[r][AW-1:TW-1])) begin
        res[r] = shf[r][TW-1:0];
        sat[r] = 1'b0;
      end else begin
        res[r] = shf[r][AW-1] ? atx_pkg::OUT_MIN : atx_pkg::OUT_MAX;
        sat[r] = 1'b1;
      end
    end
    out_data_nxt.out_x    = res[0];
    out_data_nxt.out_y    = res[1];
    out_data_nxt.out_z    = res[2];
    out_data_nxt.sat_flag = |sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < atx_pkg::NCOEF; i++) begin
        coef_r[i] <= ((i / NC) == (i % NC)) ? atx_pkg::COEF_ONE : atx_pkg::COEF_ZERO;
      end
    end else if (pop && head_item.is_load) begin
      coef_r[head_item.idx] <= head_item.coef;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= pop && !head_item.is_load;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r     <= prod_nxt;
      sum_r      <= sum_nxt;
      rnd_r      <= rnd_nxt;
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: hw/rtl/affine_point_transform_core.sv
// Top level of the affine point transform core.
// The input channel (in_valid, in_stall, in_data) takes two kinds of item.
// A load item writes one Q16.16 coefficient of the 3x4 matrix at row_sel,
// col_sel; a load to row 3 is accepted and dropped. A transform item brings
// x, y, z and weight w and yields one result item on the output channel
// (out_valid, out_stall, out_data): the three row dot products, rounded to
// Q16.16 and saturated, with sat_flag set if any row clipped.
// Items are taken in order; a load affects only transform items after it.
// Throughput is one item per cycle while out_stall does not freeze the back
// end. A transform item passes from the four-entry queue through the multiply
// stage, the pair-add stage and the final add/round stage, whose saturation
// logic feeds the output register that drives out_valid.
// Reset clears the queue and pipeline and loads the identity matrix.
// While out_stall holds a waiting result, the back end freezes and the queue
// fills; in_stall rises once the four queue entries are taken.
module affine_point_transform_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  atx_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output atx_pkg::out_item_t out_data
);

  atx_pkg::q_stat_t q_stat;
  atx_pkg::q_item_t push_item;
  atx_pkg::q_item_t head_item;
  logic             push;
  logic             pop;

  atx_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  atx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  atx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_item (head_item),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= atx_pkg::QCW'(atx_pkg::QDEPTH))
    else $error("queue count exceeds depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_free_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> (!in_stall && !out_valid))
    else $error("block not idle after reset");

  a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.full && !pop) |=> q_stat.full)
    else $error("full queue drained without pop");

endmodule
